FILE: rtl/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned PRIO_W      = 32;
  localparam int unsigned ITEM_W      = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One finished result, minus the entry count whose width follows the depth.
  typedef struct packed {
    status_e             status;
    logic [PRIO_W-1:0]   prio;
    logic [ITEM_W-1:0]   data;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/bmhq_ram.sv
`default_nettype none

module bmhq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/bmhq_seq.sv
`default_nettype none

module bmhq_seq
  import bmhq_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(HEAP_DEPTH),
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1),
  localparam int unsigned EW = PRIO_W + DATA_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cmd_e              in_cmd_i,
  input  wire logic [PRIO_W-1:0] in_prio_i,
  input  wire logic [ITEM_W-1:0] in_data_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o,
  output logic      [CW-1:0]     count_o,
  output logic                   ram_we_o,
  output logic      [AW-1:0]     ram_waddr_o,
  output logic      [EW-1:0]     ram_wdata_o,
  output logic      [AW-1:0]     ram_raddr_o,
  input  wire logic [EW-1:0]     ram_rdata_i
);

  localparam int unsigned IW = AW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(HEAP_DEPTH);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_UP_RD    = 12'b0000_0000_0010,
    S_UP_CMP   = 12'b0000_0000_0100,
    S_POP_RT   = 12'b0000_0000_1000,
    S_POP_LAST = 12'b0000_0001_0000,
    S_POP_LD   = 12'b0000_0010_0000,
    S_DN_L     = 12'b0000_0100_0000,
    S_DN_R     = 12'b0000_1000_0000,
    S_DN_SEL   = 12'b0001_0000_0000,
    S_DN_CMP   = 12'b0010_0000_0000,
    S_WR       = 12'b0100_0000_0000,
    S_FIN      = 12'b1000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [EW-1:0]   cur_q, cur_d;
  logic [EW-1:0]   best_q, best_d;
  logic [AW-1:0]   bidx_q, bidx_d;
  res_t            res_q, res_d;

  logic [IW-1:0]     lft, rgt, fill_x;
  logic [AW-1:0]     parent;
  logic [PRIO_W-1:0] cmp_a, cmp_b;
  logic              cmp_lt;

  assign lft    = {pos_q, 1'b0} + IW'(1);
  assign rgt    = lft + IW'(1);
  assign fill_x = IW'(fill_q);
  assign parent = (pos_q - AW'(1)) >> 1;

  // Shared priority comparator: the only priority compare in the datapath.
  always_comb begin
    case (state_q)
      S_UP_CMP: begin
        cmp_a = cur_q[PRIO_W-1:0];
        cmp_b = ram_rdata_i[PRIO_W-1:0];
      end
      S_DN_SEL: begin
        cmp_a = ram_rdata_i[PRIO_W-1:0];
        cmp_b = best_q[PRIO_W-1:0];
      end
      default: begin
        cmp_a = best_q[PRIO_W-1:0];
        cmp_b = cur_q[PRIO_W-1:0];
      end
    endcase
  end

  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    best_d      = best_q;
    bidx_d      = bidx_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = cur_q;
    ram_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.data   = '0;
          res_d.prio   = '0;
          res_d.status = ST_OK;
          if (in_cmd_i == CMD_PUSH) begin
            if (fill_q == FULL_CNT) begin
              res_d.status = ST_FULL;
              state_d      = S_FIN;
            end else begin
              // The new entry rides in cur_q while the hole climbs.
              cur_d   = {DATA_WIDTH'(in_data_i), in_prio_i};
              pos_d   = AW'(fill_q);
              fill_d  = fill_q + CW'(1);
              state_d = (fill_q == '0) ? S_WR : S_UP_RD;
            end
          end else begin
            if (fill_q == '0) begin
              res_d.status = ST_EMPTY;
              state_d      = S_FIN;
            end else begin
              fill_d  = fill_q - CW'(1);
              state_d = S_POP_RT;
            end
          end
        end
      end
      S_UP_RD: begin
        ram_raddr_o = parent;
        state_d     = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (cmp_lt) begin
          // Move the parent down into the hole.
          ram_we_o    = 1'b1;
          ram_wdata_o = ram_rdata_i;
          pos_d       = parent;
          state_d     = (parent == '0) ? S_WR : S_UP_RD;
        end else begin
          state_d = S_WR;
        end
      end
      S_POP_RT: begin
        ram_raddr_o = '0;
        state_d     = S_POP_LAST;
      end
      S_POP_LAST: begin
        res_d.data  = ITEM_W'(ram_rdata_i[EW-1:PRIO_W]);
        res_d.prio  = ram_rdata_i[PRIO_W-1:0];
        ram_raddr_o = AW'(fill_q);
        state_d     = (fill_q == '0) ? S_FIN : S_POP_LD;
      end
      S_POP_LD: begin
        cur_d   = ram_rdata_i;
        pos_d   = '0;
        state_d = S_DN_L;
      end
      S_DN_L: begin
        if (lft < fill_x) begin
          ram_raddr_o = lft[AW-1:0];
          state_d     = S_DN_R;
        end else begin
          state_d = S_WR;
        end
      end
      S_DN_R: begin
        best_d = ram_rdata_i;
        bidx_d = lft[AW-1:0];
        if (rgt < fill_x) begin
          ram_raddr_o = rgt[AW-1:0];
          state_d     = S_DN_SEL;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_SEL: begin
        if (cmp_lt) begin
          best_d = ram_rdata_i;
          bidx_d = rgt[AW-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (cmp_lt) begin
          // Pull the smaller child up into the hole.
          ram_we_o    = 1'b1;
          ram_wdata_o = best_q;
          pos_d       = bidx_q;
          state_d     = S_DN_L;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        ram_we_o = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cur_q  <= cur_d;
    best_q <= best_d;
    bidx_q <= bidx_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);
  assign res_o       = res_q;
  assign count_o     = fill_q;

endmodule

`default_nettype wire

FILE: rtl/binary_min_heap_queue.sv
`default_nettype none

// Channel  Dir  tdata (low bit up)                               tuser
// s_axis   in   key_priority[31:0], item_data[63:32]             cmd
// m_axis   out  popped_data[31:0], popped_priority[63:32],       status
//               entry_count[70:64], not_empty[71]
//
// One word at a time: s_axis_tready is low from acceptance until the result
// has moved into the output register. A push moves its hole up level by level; a
// pop reads the root and the last entry and sifts that entry down, reading each
// existing left and right child in turn. The heap RAM's single registered read
// port and the shared comparator serialize these steps. Reset empties the heap at
// once; a stalled m_axis holds the finished word and the next word waits in the
// sequencer.

module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // key_priority, item_data
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [71:0] m_axis_tdata,  // popped_data, popped_priority,
                                          // entry_count, not_empty
  output logic      [1:0]  m_axis_tuser   // status
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned EW = PRIO_W + DATA_WIDTH;

  logic          res_valid, res_ready;
  res_t          res;
  logic [CW-1:0] count;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic          out_valid_q, out_valid_d;
  res_t          out_res_q;
  logic [CW-1:0] out_cnt_q;
  logic          load;

  bmhq_seq #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_prio_i   (s_axis_tdata[31:0]),
    .in_data_i   (s_axis_tdata[63:32]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .count_o     (count),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: take a new word whenever the slot is free or draining.
  assign res_ready = !out_valid_q || m_axis_tready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q <= res;
      out_cnt_q <= count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(out_cnt_q != '0), COUNT_OUT_W'(out_cnt_q),
                          out_res_q.prio, out_res_q.data};
  assign m_axis_tuser  = out_res_q.status;

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_empty_pop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.status == ST_EMPTY) |->
      (out_cnt_q == '0) && (out_res_q.prio == '0) && (out_res_q.data == '0))
    else $error("empty pop word carries an entry");

  a_full_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.status == ST_FULL) |-> out_cnt_q == CW'(HEAP_DEPTH))
    else $error("full push reported below capacity");

  a_no_load_while_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !load)
    else $error("output word overwritten while stalled");
`endif

endmodule

`default_nettype wire
